// ===== design/hexesc_pkg.sv =====
// Shared types, byte constants and lookup functions for the hex escape run decoder.
// Used by hexesc_step, hexesc_outq and hex_escape_run_decoder_top; no dependencies.
package hexesc_pkg;

    localparam int MAX_RUN_DEF = 4096;
    localparam int RES_SLOTS   = 6;
    localparam int OPEN_LEN    = 5;
    localparam int CLOSE_LEN   = 10;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_H      = 8'h48;
    localparam logic [7:0] CH_E      = 8'h45;
    localparam logic [7:0] CH_X      = 8'h58;
    localparam logic [7:0] CH_N      = 8'h4E;
    localparam logic [7:0] CH_D      = 8'h44;

    typedef enum logic [2:0] {
        PH_PLAIN,
        PH_COUNT,
        PH_SKIP,
        PH_HEX,
        PH_CLOSE,
        PH_FAIL
    } t_phase;

    // Decoder state apart from the run length, whose width follows MAX_RUN.
    typedef struct packed {
        t_phase      phase;
        logic [2:0]  opener_matched;
        logic        count_digits_seen;
        logic        dollar_pending;
        logic [1:0]  nibble_index;
        logic [15:0] char_accum;
        logic [3:0]  closer_matched;
    } t_state;

    localparam t_state STATE_RST = '{
        phase:             PH_PLAIN,
        opener_matched:    3'd0,
        count_digits_seen: 1'b0,
        dollar_pending:    1'b0,
        nibble_index:      2'd0,
        char_accum:        16'd0,
        closer_matched:    4'd0
    };

    typedef struct packed {
        logic [15:0] out_char;
        logic        char_valid;
        logic        decode_error;
        logic        last_result;
    } t_res;

    // All results caused by one request, oldest in slot 0.
    typedef struct packed {
        t_res [RES_SLOTS-1:0] r;
        logic [2:0]           cnt;
    } t_bundle;

    function automatic t_bundle bundle_push(t_bundle bd, logic [15:0] ch, logic vld,
                                            logic err);
        t_bundle o;
        o = bd;
        if (bd.cnt < 3'(RES_SLOTS)) begin
            o.r[bd.cnt] = '{out_char: ch, char_valid: vld, decode_error: err,
                            last_result: 1'b0};
            o.cnt = bd.cnt + 3'd1;
        end
        return o;
    endfunction

    function automatic logic [7:0] open_byte(logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = CH_DOLLAR;
            3'd1:    b = CH_DOLLAR;
            3'd2:    b = CH_H;
            3'd3:    b = CH_E;
            3'd4:    b = CH_X;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    function automatic logic [7:0] close_byte(logic [3:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = CH_DOLLAR;
            4'd1:    b = CH_DOLLAR;
            4'd2:    b = CH_E;
            4'd3:    b = CH_N;
            4'd4:    b = CH_D;
            4'd5:    b = CH_H;
            4'd6:    b = CH_E;
            4'd7:    b = CH_X;
            4'd8:    b = CH_DOLLAR;
            4'd9:    b = CH_DOLLAR;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // {ok, value} of an ASCII hex digit.
    function automatic logic [4:0] hex_value(logic [7:0] b);
        logic [4:0] v;
        if (b >= 8'h30 && b <= 8'h39) begin
            v = {1'b1, b[3:0]};
        end else if (b >= 8'h61 && b <= 8'h66) begin
            v = {1'b1, 4'(b[3:0] + 4'd9)};
        end else if (b >= 8'h41 && b <= 8'h46) begin
            v = {1'b1, 4'(b[3:0] + 4'd9)};
        end else begin
            v = 5'd0;
        end
        return v;
    endfunction

    function automatic logic is_space(logic [7:0] b);
        return (b == 8'h20) || (b >= 8'h09 && b <= 8'h0D);
    endfunction

endpackage

// ===== design/hexesc_step.sv =====
// Next-state and result logic for one byte of the escaped stream.
// Purely combinational; depends on hexesc_pkg.
module hexesc_step #(
    parameter int MAX_RUN = hexesc_pkg::MAX_RUN_DEF,
    localparam int RL_W   = $clog2(MAX_RUN + 2)
) (
    input  hexesc_pkg::t_state  i_st,
    input  logic [RL_W-1:0]     i_rl,
    input  logic [7:0]          i_byte,
    input  logic                i_eot,
    output hexesc_pkg::t_state  o_st,
    output logic [RL_W-1:0]     o_rl,
    output hexesc_pkg::t_bundle o_bd
);

    localparam int VW = RL_W + 4;
    localparam logic [VW-1:0] MAX_V = VW'(MAX_RUN);
    localparam logic [VW-1:0] SAT_V = VW'(MAX_RUN + 1);

    always_comb begin
        hexesc_pkg::t_state  st;
        logic [RL_W-1:0]     rl;
        hexesc_pkg::t_bundle bd;
        logic [2:0]          m;
        logic [VW-1:0]       v;
        logic [4:0]          hv;
        logic [15:0]         acc;

        st = i_st;
        rl = i_rl;
        bd = '0;
        m  = i_st.opener_matched;
        v  = '0;
        hv = hexesc_pkg::hex_value(i_byte);
        acc = i_st.char_accum;

        if (i_st.phase == hexesc_pkg::PH_FAIL) begin
            if (i_eot) begin
                bd = hexesc_pkg::bundle_push(bd, 16'd0, 1'b0, 1'b1);
            end
        end else begin
            case (i_st.phase)
                hexesc_pkg::PH_PLAIN: begin
                    if (m < 3'(hexesc_pkg::OPEN_LEN) && i_byte == hexesc_pkg::open_byte(m)) begin
                        if (m == 3'(hexesc_pkg::OPEN_LEN - 1)) begin
                            st.phase             = hexesc_pkg::PH_COUNT;
                            st.opener_matched    = 3'd0;
                            st.count_digits_seen = 1'b0;
                            st.dollar_pending    = 1'b0;
                            rl                   = '0;
                        end else begin
                            st.opener_matched = m + 3'd1;
                        end
                    end else if (m == 3'd2 && i_byte == hexesc_pkg::CH_DOLLAR) begin
                        // "$$$": oldest dollar falls out, prefix stays "$$"
                        bd = hexesc_pkg::bundle_push(bd, {8'h00, hexesc_pkg::CH_DOLLAR},
                                                     1'b1, 1'b0);
                    end else begin
                        for (int i = 0; i < hexesc_pkg::OPEN_LEN - 1; i++) begin
                            if (3'(i) < m) begin
                                bd = hexesc_pkg::bundle_push(bd,
                                        {8'h00, hexesc_pkg::open_byte(3'(i))}, 1'b1, 1'b0);
                            end
                        end
                        st.opener_matched = 3'd0;
                        if (i_byte == hexesc_pkg::CH_DOLLAR) begin
                            st.opener_matched = 3'd1;
                        end else begin
                            bd = hexesc_pkg::bundle_push(bd, {8'h00, i_byte}, 1'b1, 1'b0);
                        end
                    end
                end
                hexesc_pkg::PH_COUNT, hexesc_pkg::PH_SKIP: begin
                    if (i_st.dollar_pending) begin
                        st.dollar_pending = 1'b0;
                        if (i_byte == hexesc_pkg::CH_DOLLAR) begin
                            if (!i_st.count_digits_seen || i_rl == '0
                                    || VW'(i_rl) > MAX_V) begin
                                st.phase = hexesc_pkg::PH_FAIL;
                                bd = hexesc_pkg::bundle_push(bd, 16'd0, 1'b0, 1'b1);
                            end else begin
                                st.phase        = hexesc_pkg::PH_HEX;
                                st.nibble_index = 2'd0;
                                st.char_accum   = 16'd0;
                            end
                        end
                    end else if (i_byte == hexesc_pkg::CH_DOLLAR) begin
                        st.dollar_pending = 1'b1;
                        st.phase          = hexesc_pkg::PH_SKIP;
                    end else if (i_st.phase == hexesc_pkg::PH_COUNT) begin
                        if (i_byte >= 8'h30 && i_byte <= 8'h39) begin
                            v = (VW'(i_rl) << 3) + (VW'(i_rl) << 1) + VW'(i_byte[3:0]);
                            if (v > MAX_V) begin
                                v = SAT_V;
                            end
                            rl = v[RL_W-1:0];
                            st.count_digits_seen = 1'b1;
                        end else if (!(hexesc_pkg::is_space(i_byte)
                                       && !i_st.count_digits_seen)) begin
                            st.phase = hexesc_pkg::PH_SKIP;
                        end
                    end
                end
                hexesc_pkg::PH_HEX: begin
                    if (!hv[4]) begin
                        st.phase = hexesc_pkg::PH_FAIL;
                        bd = hexesc_pkg::bundle_push(bd, 16'd0, 1'b0, 1'b1);
                    end else begin
                        // digit order fills bits 7:4, 3:0, 15:12, 11:8
                        case (i_st.nibble_index)
                            2'd0:    acc[7:4]   = acc[7:4]   | hv[3:0];
                            2'd1:    acc[3:0]   = acc[3:0]   | hv[3:0];
                            2'd2:    acc[15:12] = acc[15:12] | hv[3:0];
                            2'd3:    acc[11:8]  = acc[11:8]  | hv[3:0];
                            default: acc = i_st.char_accum;
                        endcase
                        st.char_accum   = acc;
                        st.nibble_index = i_st.nibble_index + 2'd1;
                        if (i_st.nibble_index == 2'd3) begin
                            bd = hexesc_pkg::bundle_push(bd, acc, 1'b1, 1'b0);
                            st.char_accum = 16'd0;
                            if (i_rl != '0) begin
                                rl = i_rl - RL_W'(1);
                            end
                            if (rl == '0) begin
                                st.phase          = hexesc_pkg::PH_CLOSE;
                                st.closer_matched = 4'd0;
                            end
                        end
                    end
                end
                hexesc_pkg::PH_CLOSE: begin
                    if (i_st.closer_matched >= 4'(hexesc_pkg::CLOSE_LEN)
                            || i_byte != hexesc_pkg::close_byte(i_st.closer_matched)) begin
                        st.phase = hexesc_pkg::PH_FAIL;
                        bd = hexesc_pkg::bundle_push(bd, 16'd0, 1'b0, 1'b1);
                    end else if (i_st.closer_matched == 4'(hexesc_pkg::CLOSE_LEN - 1)) begin
                        st.phase          = hexesc_pkg::PH_PLAIN;
                        st.closer_matched = 4'd0;
                        st.opener_matched = 3'd0;
                    end else begin
                        st.closer_matched = i_st.closer_matched + 4'd1;
                    end
                end
                default: begin
                    st.phase = hexesc_pkg::PH_FAIL;
                    bd = hexesc_pkg::bundle_push(bd, 16'd0, 1'b0, 1'b1);
                end
            endcase

            if (i_eot) begin
                if (st.phase == hexesc_pkg::PH_PLAIN) begin
                    for (int i = 0; i < hexesc_pkg::OPEN_LEN - 1; i++) begin
                        if (3'(i) < st.opener_matched) begin
                            bd = hexesc_pkg::bundle_push(bd,
                                    {8'h00, hexesc_pkg::open_byte(3'(i))}, 1'b1, 1'b0);
                        end
                    end
                end else if (st.phase != hexesc_pkg::PH_FAIL) begin
                    bd = hexesc_pkg::bundle_push(bd, 16'd0, 1'b0, 1'b1);
                end
            end
        end

        if (i_eot) begin
            if (bd.cnt == 3'd0) begin
                bd = hexesc_pkg::bundle_push(bd, 16'd0, 1'b0, 1'b0);
            end
            bd.r[bd.cnt - 3'd1].last_result = 1'b1;
            st = hexesc_pkg::STATE_RST;
            rl = '0;
        end

        o_st = st;
        o_rl = rl;
        o_bd = bd;
    end

endmodule

// ===== design/hexesc_outq.sv =====
// Result register: holds the results of one request and hands them out one per cycle while not stalled.
// Depends on hexesc_pkg.
module hexesc_outq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  hexesc_pkg::t_bundle i_bd,
    input  logic                i_stall,
    output logic                o_free,
    output logic                o_valid,
    output hexesc_pkg::t_res    o_res
);

    hexesc_pkg::t_res [hexesc_pkg::RES_SLOTS-1:0] r_res;
    logic [2:0]                                   r_cnt;

    assign o_valid = (r_cnt != 3'd0);
    assign o_res   = r_res[0];
    // Free when empty or once the last held result leaves in this cycle.
    assign o_free  = (r_cnt == 3'd0) || (r_cnt == 3'd1 && !i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 3'd0;
        end else if (i_load) begin
            r_cnt <= i_bd.cnt;
        end else if (o_valid && !i_stall) begin
            r_cnt <= r_cnt - 3'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_bd.r;
        end else if (o_valid && !i_stall) begin
            for (int i = 0; i < hexesc_pkg::RES_SLOTS - 1; i++) begin
                r_res[i] <= r_res[i+1];
            end
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> o_free)
        else $error("results loaded over undelivered results");

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 3'(hexesc_pkg::RES_SLOTS))
        else $error("result count out of range");

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall && !i_load |=> $stable(r_cnt))
        else $error("result count moved while stalled");

endmodule

// ===== design/hex_escape_run_decoder_top.sv =====
// Hex escape run decoder: plain bytes pass through, "$$HEX<n>$$ ... $$ENDHEX$$" runs
// decode to 16-bit characters. Requests pass the input register, then the result register.
// Throughput: 1 request per cycle while each yields at most one result and the output is not
// stalled; a request yielding k results (up to 5) holds the input side until they drain.
// Reset (i_rst_n low, synchronous) returns to plain text with no held request.
module hex_escape_run_decoder_top #(
    parameter int MAX_RUN = hexesc_pkg::MAX_RUN_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_end_of_text,
    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_out_char,
    output logic        o_char_valid,
    output logic        o_decode_error,
    output logic        o_last_result
);

    localparam int RL_W = $clog2(MAX_RUN + 2);

    // Input register: one request waiting to be decoded.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_eot;

    // Decoder state.
    hexesc_pkg::t_state r_st;
    logic [RL_W-1:0]    r_rl;
    hexesc_pkg::t_state n_st;
    logic [RL_W-1:0]    n_rl;

    hexesc_pkg::t_bundle step_bd;
    hexesc_pkg::t_res    head;
    logic                q_free;
    logic                advance;
    logic                in_take;

    // Decode the held request once the result register is empty or drains in this cycle.
    assign advance    = r_in_valid && q_free;
    assign o_in_stall = r_in_valid && !q_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    // Payload: capture on accept, hold otherwise.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
            r_in_eot  <= i_end_of_text;
        end
    end

    hexesc_step #(
        .MAX_RUN (MAX_RUN)
    ) u_step (
        .i_st   (r_st),
        .i_rl   (r_rl),
        .i_byte (r_in_byte),
        .i_eot  (r_in_eot),
        .o_st   (n_st),
        .o_rl   (n_rl),
        .o_bd   (step_bd)
    );

    // Advance the state only when the request's results are taken into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= hexesc_pkg::STATE_RST;
            r_rl <= '0;
        end else if (advance) begin
            r_st <= n_st;
            r_rl <= n_rl;
        end
    end

    hexesc_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_bd    (step_bd),
        .i_stall (i_out_stall),
        .o_free  (q_free),
        .o_valid (o_out_valid),
        .o_res   (head)
    );

    assign o_out_char     = head.out_char;
    assign o_char_valid   = head.char_valid;
    assign o_decode_error = head.decode_error;
    assign o_last_result  = head.last_result;

    // An error report never carries a character.
    a_err_no_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_decode_error |-> !o_char_valid && o_out_char == 16'd0)
        else $error("error report carries a character");

    // The end of a stream returns the decoder to plain text.
    a_eot_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_eot |=> r_st.phase == hexesc_pkg::PH_PLAIN
                                && r_st.opener_matched == 3'd0 && r_rl == '0)
        else $error("state not cleared after end of text");

    // The final request of a stream always produces at least one result.
    a_eot_has_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in_eot |-> step_bd.cnt != 3'd0)
        else $error("end of text without a result");

    // No opener prefix is held once an escape has failed.
    a_fail_no_prefix: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase == hexesc_pkg::PH_FAIL |-> r_st.opener_matched == 3'd0)
        else $error("opener prefix held in failed state");

endmodule
